### hdl/b2c_pkg.sv
// Shared types and constants of the byte to C literal text encoder.
package b2c_pkg;

    // Depth of the job queue between front and back; must be a power of two.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int COL_W = 11;
    localparam logic [COL_W-1:0] COLUMN_MAX = 11'd2047;

    // Output modes.
    localparam logic [1:0] MODE_DEC     = 2'd0;
    localparam logic [1:0] MODE_HEXLIST = 2'd1;
    localparam logic [1:0] MODE_HEXSTR  = 2'd2;
    localparam logic [1:0] MODE_ESCSTR  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_MAX_COLUMNS = 2'd1;
    localparam logic [1:0] REG_DROP_CR     = 2'd2;

    // Input operations.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] max_columns;
        logic       drop_cr;
    } cfg_t;

    // Opening text of a resource.
    typedef enum logic [1:0] {
        OPEN_NONE,
        OPEN_STR,       // =\n  "
        OPEN_LIST,      // ={
        OPEN_LIST_NL    // ={\n and two spaces
    } open_code_t;

    // Line wrap text.
    typedef enum logic [1:0] {
        WRAP_NONE,
        WRAP_STR,       // "\n  "
        WRAP_LIST       // \n and two spaces
    } wrap_code_t;

    // Main text of an item; every job has one.
    typedef enum logic [3:0] {
        BODY_CHAR,
        BODY_ESC,
        BODY_NL,
        BODY_HEXESC,
        BODY_HEX0X,
        BODY_DEC,
        BODY_CLOSE_STR,
        BODY_CLOSE_LIST,
        BODY_CLOSE_LIST_NL
    } body_code_t;

    // One classified item as handed from front to back.
    typedef struct packed {
        open_code_t open_code;
        logic       comma;
        wrap_code_t wrap_code;
        body_code_t body_code;
        logic [7:0] data;
    } job_t;

    // Segment that the back end is emitting.
    typedef enum logic [1:0] {
        PH_OPEN,
        PH_COMMA,
        PH_WRAP,
        PH_BODY
    } phase_t;

endpackage

### hdl/byte_to_c_literal_text_encoder.sv
// Top level of the byte to C literal text encoder: configuration registers and wiring.
// Path: an accepted item passes the job queue, the job register of the back end and its output register.
// Throughput: one character per cycle while the receiver keeps popping, set by the single character
// path of the back end; an item gives 1 to 12 characters, about 4 for a typical byte, and a dropped
// carriage return gives none. Reset: all control state clears at once; the registers return to hex
// list mode, 16 columns and carriage returns kept.
module byte_to_c_literal_text_encoder (
    input  logic       clk,
    input  logic       rst_n,
    // Input item queue side.
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [7:0] data_byte,
    // Result queue side.
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       last_char,
    // Configuration write port.
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [9:0] wr_data
);
    import b2c_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic accept;
    job_t front_job;
    logic front_we;
    job_t q_job;
    logic q_empty;
    logic q_pop;

    // The configuration registers. Writes to an index past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_MODE:        cfg_next.mode        = wr_data[1:0];
                REG_MAX_COLUMNS: cfg_next.max_columns = wr_data;
                REG_DROP_CR:     cfg_next.drop_cr     = wr_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_HEXLIST;
            cfg_reg.max_columns <= 10'd16;
            cfg_reg.drop_cr     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // An item is taken whenever the job queue has room. The front end does all the
    // line bookkeeping in that same cycle, so the next item may follow right away.
    assign accept = push && !full;

    b2c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .op        (op),
        .data_byte (data_byte),
        .job       (front_job),
        .job_we    (front_we)
    );

    // The queue absorbs the spread between one item per cycle in and one character
    // per cycle out, so the front keeps taking items while long texts drain.
    b2c_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (front_we),
        .wdata (front_job),
        .full  (full),
        .re    (q_pop),
        .rdata (q_job),
        .empty (q_empty)
    );

    // The back end walks opening, comma, wrap and body text of each job and loads
    // the next job on the cycle of the last character, with no gap between items when the queue holds one.
    b2c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_job     (q_job),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

### hdl/b2c_fifo.sv
// Small job queue that decouples the classifying front from the text back end.
module b2c_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  b2c_pkg::job_t wdata,
    output logic          full,
    input  logic          re,
    output b2c_pkg::job_t rdata,
    output logic          empty
);
    import b2c_pkg::*;

    job_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_wr;
    logic           do_rd;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];
    assign do_wr = we && !full;
    assign do_rd = re && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hdl/b2c_front.sv
// Front end: takes input items, keeps the line state and classifies each item into a job.
module b2c_front (
    input  logic          clk,
    input  logic          rst_n,
    input  b2c_pkg::cfg_t cfg,
    input  logic          accept,
    input  logic          op,
    input  logic [7:0]    data_byte,
    output b2c_pkg::job_t job,
    output logic          job_we
);
    import b2c_pkg::*;

    logic [COL_W-1:0] column_reg;
    logic [COL_W-1:0] column_next;
    logic             hex_pending_reg;
    logic             hex_pending_next;
    logic             first_item_reg;
    logic             first_item_next;
    logic             opened_reg;
    logic             opened_next;

    logic             drop;
    logic             wrap_due;
    logic             col_clear;
    logic [COL_W-1:0] col_base;
    logic [2:0]       col_add;
    logic [COL_W:0]   col_sum;

    function automatic logic is_xdigit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    always_comb
    begin
        job.open_code = OPEN_NONE;
        job.comma     = 1'b0;
        job.wrap_code = WRAP_NONE;
        job.body_code = BODY_CHAR;
        job.data      = data_byte;
        job_we        = 1'b0;

        hex_pending_next = hex_pending_reg;
        first_item_next  = first_item_reg;
        opened_next      = opened_reg;
        col_clear        = 1'b0;
        col_base         = column_reg;
        col_add          = 3'd0;

        drop     = (op == OP_DATA) && cfg.drop_cr && (data_byte == 8'h0D);
        wrap_due = (cfg.max_columns != '0) && (column_reg >= {1'b0, cfg.max_columns});

        if (!opened_reg)
        begin
            if (cfg.mode[1])
            begin
                job.open_code = OPEN_STR;
            end
            else if (cfg.max_columns != '0)
            begin
                job.open_code = OPEN_LIST_NL;
            end
            else
            begin
                job.open_code = OPEN_LIST;
            end
        end

        if (op == OP_FINISH)
        begin
            job_we = accept;
            if (cfg.mode[1])
            begin
                job.body_code = BODY_CLOSE_STR;
            end
            else if (cfg.max_columns != '0)
            begin
                job.body_code = BODY_CLOSE_LIST_NL;
            end
            else
            begin
                job.body_code = BODY_CLOSE_LIST;
            end
            col_clear        = 1'b1;
            hex_pending_next = 1'b0;
            first_item_next  = 1'b1;
            opened_next      = 1'b0;
        end
        else if (!drop)
        begin
            job_we      = accept;
            opened_next = 1'b1;
            if (cfg.mode[1])
            begin
                if (wrap_due)
                begin
                    job.wrap_code = WRAP_STR;
                    col_base      = '0;
                end
                if (cfg.mode == MODE_ESCSTR)
                begin
                    hex_pending_next = 1'b0;
                    job.body_code    = BODY_ESC;
                    col_add          = 3'd2;
                    case (data_byte)
                        8'h5C:   job.data = 8'h5C;
                        8'h07:   job.data = "a";
                        8'h09:   job.data = "t";
                        8'h0D:   job.data = "r";
                        8'h0C:   job.data = "f";
                        8'h0B:   job.data = "v";
                        8'h22:   job.data = 8'h22;
                        8'h0A:
                        begin
                            job.body_code = BODY_NL;
                            col_clear     = 1'b1;
                        end
                        default:
                        begin
                            // Control and high bytes, and a hex digit right after a
                            // hex escape, become hex escapes themselves.
                            if (data_byte < 8'd32 || data_byte >= 8'd127
                                || (hex_pending_reg && is_xdigit(data_byte)))
                            begin
                                job.body_code    = BODY_HEXESC;
                                col_add          = 3'd4;
                                hex_pending_next = 1'b1;
                            end
                            else
                            begin
                                job.body_code = BODY_CHAR;
                                col_add       = 3'd1;
                            end
                        end
                    endcase
                end
                else
                begin
                    job.body_code = BODY_HEXESC;
                    col_add       = 3'd4;
                end
            end
            else
            begin
                job.comma = !first_item_reg;
                if (wrap_due)
                begin
                    job.wrap_code = WRAP_LIST;
                    col_base      = '0;
                end
                job.body_code   = (cfg.mode == MODE_HEXLIST) ? BODY_HEX0X : BODY_DEC;
                first_item_next = 1'b0;
                col_add         = 3'd1;
            end
        end

        col_sum = {1'b0, col_base} + {{(COL_W-2){1'b0}}, col_add};
        if (col_clear)
        begin
            column_next = '0;
        end
        else if (col_sum[COL_W])
        begin
            column_next = COLUMN_MAX;
        end
        else
        begin
            column_next = col_sum[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            hex_pending_reg <= 1'b0;
            first_item_reg  <= 1'b1;
            opened_reg      <= 1'b0;
        end
        else if (accept)
        begin
            column_reg      <= column_next;
            hex_pending_reg <= hex_pending_next;
            first_item_reg  <= first_item_next;
            opened_reg      <= opened_next;
        end
    end

endmodule

### hdl/b2c_back.sv
// Back end: expands queued jobs into characters, one a cycle while the output is taken, into an output register.
module b2c_back (
    input  logic          clk,
    input  logic          rst_n,
    input  b2c_pkg::job_t q_job,
    input  logic          q_empty,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_char,
    output logic          last_char
);
    import b2c_pkg::*;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    job_t       job_reg;
    job_t       job_next;
    logic       job_valid_reg;
    logic       job_valid_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       out_last_reg;
    logic       out_last_next;

    logic [2:0] seg_len;
    logic       at_end;
    logic       is_last;
    logic       out_ready;
    logic       emit;
    logic       take;
    logic [7:0] cur_char;

    function automatic phase_t after_phase(input phase_t p, input job_t j);
        phase_t r;
        case (p)
            PH_OPEN:  r = j.comma ? PH_COMMA : ((j.wrap_code != WRAP_NONE) ? PH_WRAP : PH_BODY);
            PH_COMMA: r = (j.wrap_code != WRAP_NONE) ? PH_WRAP : PH_BODY;
            default:  r = PH_BODY;
        endcase
        return r;
    endfunction

    function automatic phase_t start_phase(input job_t j);
        return (j.open_code != OPEN_NONE) ? PH_OPEN : after_phase(PH_OPEN, j);
    endfunction

    function automatic logic [2:0] length_of(input phase_t p, input job_t j);
        logic [2:0] n;
        n = 3'd1;
        case (p)
            PH_OPEN:  n = (j.open_code == OPEN_LIST) ? 3'd2 : 3'd5;
            PH_COMMA: n = 3'd1;
            PH_WRAP:  n = (j.wrap_code == WRAP_STR) ? 3'd5 : 3'd3;
            PH_BODY:
            begin
                case (j.body_code)
                    BODY_CHAR:          n = 3'd1;
                    BODY_ESC:           n = 3'd2;
                    BODY_NL:            n = 3'd7;
                    BODY_HEXESC:        n = 3'd4;
                    BODY_HEX0X:         n = 3'd4;
                    BODY_DEC:           n = 3'd3;
                    BODY_CLOSE_STR:     n = 3'd4;
                    BODY_CLOSE_LIST:    n = 3'd1;
                    BODY_CLOSE_LIST_NL: n = 3'd4;
                    default:            n = 3'd1;
                endcase
            end
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h57 + {4'd0, n});
    endfunction

    function automatic logic [7:0] char_of(input phase_t p, input job_t j, input logic [2:0] i);
        logic [7:0]  c;
        logic [1:0]  h;
        logic [7:0]  rem8;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  u7;
        c = CH_SP;
        // Decimal digits: hundreds by compare, tens by multiply with 205/2048.
        h    = (j.data >= 8'd200) ? 2'd2 : ((j.data >= 8'd100) ? 2'd1 : 2'd0);
        rem8 = j.data - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
        prod = 15'(rem8[6:0]) * 15'd205;
        t    = prod[14:11];
        u7   = rem8[6:0] - 7'(t) * 7'd10;
        case (p)
            PH_OPEN:
            begin
                if (j.open_code == OPEN_STR)
                begin
                    case (i)
                        3'd0:    c = "=";
                        3'd1:    c = CH_NL;
                        3'd2:    c = CH_SP;
                        3'd3:    c = CH_SP;
                        default: c = CH_QUOTE;
                    endcase
                end
                else
                begin
                    case (i)
                        3'd0:    c = "=";
                        3'd1:    c = "{";
                        3'd2:    c = CH_NL;
                        default: c = CH_SP;
                    endcase
                end
            end
            PH_COMMA: c = ",";
            PH_WRAP:
            begin
                if (j.wrap_code == WRAP_STR)
                begin
                    case (i)
                        3'd0:    c = CH_QUOTE;
                        3'd1:    c = CH_NL;
                        3'd2:    c = CH_SP;
                        3'd3:    c = CH_SP;
                        default: c = CH_QUOTE;
                    endcase
                end
                else
                begin
                    c = (i == 3'd0) ? CH_NL : CH_SP;
                end
            end
            default:
            begin
                case (j.body_code)
                    BODY_CHAR: c = j.data;
                    BODY_ESC:  c = (i == 3'd0) ? CH_BSL : j.data;
                    BODY_NL:
                    begin
                        case (i)
                            3'd0:    c = CH_BSL;
                            3'd1:    c = "n";
                            3'd2:    c = CH_QUOTE;
                            3'd3:    c = CH_NL;
                            3'd4:    c = CH_SP;
                            3'd5:    c = CH_SP;
                            default: c = CH_QUOTE;
                        endcase
                    end
                    BODY_HEXESC, BODY_HEX0X:
                    begin
                        case (i)
                            3'd0:    c = (j.body_code == BODY_HEXESC) ? CH_BSL : "0";
                            3'd1:    c = "x";
                            3'd2:    c = hex_char(j.data[7:4]);
                            default: c = hex_char(j.data[3:0]);
                        endcase
                    end
                    BODY_DEC:
                    begin
                        case (i)
                            3'd0:    c = (h != 2'd0) ? (8'h30 + {6'd0, h}) : CH_SP;
                            3'd1:    c = (h != 2'd0 || t != 4'd0) ? (8'h30 + {4'd0, t}) : CH_SP;
                            default: c = 8'h30 + {1'b0, u7};
                        endcase
                    end
                    BODY_CLOSE_STR:
                    begin
                        case (i)
                            3'd0:    c = CH_QUOTE;
                            3'd1:    c = CH_NL;
                            default: c = CH_SP;
                        endcase
                    end
                    BODY_CLOSE_LIST: c = "}";
                    BODY_CLOSE_LIST_NL:
                    begin
                        case (i)
                            3'd0:    c = CH_NL;
                            3'd1:    c = CH_SP;
                            3'd2:    c = CH_SP;
                            default: c = "}";
                        endcase
                    end
                    default: c = CH_SP;
                endcase
            end
        endcase
        return c;
    endfunction

    assign seg_len   = length_of(phase_reg, job_reg);
    assign at_end    = (idx_reg == seg_len - 3'd1);
    assign is_last   = (phase_reg == PH_BODY) && at_end;
    assign out_ready = !out_valid_reg || pop;
    assign emit      = job_valid_reg && out_ready;
    assign take      = !q_empty && (!job_valid_reg || (emit && is_last));
    assign q_pop     = take;

    // Next state of the segment sequencer.
    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        if (take)
        begin
            job_next       = q_job;
            job_valid_next = 1'b1;
            phase_next     = start_phase(q_job);
            idx_next       = 3'd0;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                job_valid_next = 1'b0;
            end
            else if (at_end)
            begin
                phase_next = after_phase(phase_reg, job_reg);
                idx_next   = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    // Character output.
    always_comb
    begin
        cur_char       = char_of(phase_reg, job_reg, idx_reg);
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_ready)
        begin
            out_valid_next = emit;
            out_char_next  = cur_char;
            out_last_next  = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_OPEN;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign empty     = !out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = out_last_reg;

endmodule

### hdl/b2c_checker.sv
// Port level checks of the byte to C literal text encoder and their binding.
module b2c_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_char,
    input logic       last_char
);

    // No result is shown once reset has been applied at a clock edge.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_char) && $stable(last_char))
        else $error("waiting result changed");

    // The characters of one item follow without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_char |=> !empty)
        else $error("gap inside the text of one item");

    // Every character is a nonzero seven-bit ASCII code.
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !out_char[7] && out_char != 8'h00)
        else $error("character outside ASCII text");

    // The queue fills only through accepted items.
    a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an item");

endmodule

bind byte_to_c_literal_text_encoder b2c_checker u_checker (.*);

### tb/byte_to_c_literal_text_encoder_tb.sv
// Self-checking testbench of the byte to C literal text encoder.
module byte_to_c_literal_text_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import b2c_pkg::*;

    // How often a side of the queue interface idles between items.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_SOME  = 1;
    localparam int IDLE_HEAVY = 2;

    // Cycles to let pass after the last expected character before the block
    // counts as idle; a trailing dropped carriage return produces no character.
    localparam int SETTLE_CYCLES = 8;

    // Length of the long receiver hold-off that fills the block up.
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [7:0] CR_BYTE = 8'h0d;

    // One character of generated text as the result port shows it.
    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } text_char_t;

    // One input item waiting to be offered, with the idle cycles before it.
    typedef struct {
        logic       op;
        logic [7:0] data;
        int         gap;
    } feed_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       op = OP_DATA;
    logic [7:0] data_byte = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_char;
    logic       last_char;
    logic       wr_en = 1'b0;
    logic [1:0] wr_index = REG_MODE;
    logic [9:0] wr_data = 10'd0;

    byte_to_c_literal_text_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last_char (last_char),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Items still to be offered, and characters still to be received.
    feed_item_t byte_feed[$];
    text_char_t text_due[$];

    int errors = 0;
    int send_idle = IDLE_NONE;
    int recv_idle = IDLE_NONE;

    // Set by the stimulus to make the receiver stop popping for a long stretch.
    bit hold_req = 1'b0;

    // Copy of the configuration registers, updated as they are written.
    logic [1:0] cfg_mode = MODE_HEXLIST;
    logic [9:0] cfg_cols = 10'd16;
    logic       cfg_drop = 1'b0;

    // Encoder state as the predictor sees it.
    logic [COL_W-1:0] line_col = '0;
    logic             hex_pend = 1'b0;
    logic             list_first = 1'b1;
    logic             res_open = 1'b0;

    // Characters of the item that is being encoded.
    logic [7:0] char_buf[$];

    function automatic int idle_draw(input int level);
        case (level)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
            default:   return int'($urandom_range(0, 18));
        endcase
    endfunction

    function void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
    endfunction

    function void put_hex(input logic [7:0] b);
        char_buf.push_back(hex_char(b[7:4]));
        char_buf.push_back(hex_char(b[3:0]));
    endfunction

    // The column counter saturates instead of wrapping around.
    function void advance_col(input int n);
        int c;
        c = int'(line_col) + n;
        line_col = (c > int'(COLUMN_MAX)) ? COLUMN_MAX : COL_W'(c);
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic bit string_mode();
        return cfg_mode == MODE_HEXSTR || cfg_mode == MODE_ESCSTR;
    endfunction

    // One byte inside a string literal: line break first, then the byte itself.
    function void encode_string_byte(input logic [7:0] b);
        string esc;
        esc = "";
        if (cfg_cols != 0 && line_col >= cfg_cols)
        begin
            put_text("\"\n  \"");
            line_col = '0;
        end
        if (cfg_mode == MODE_ESCSTR)
        begin
            case (b)
                "\\":  esc = "\\\\";
                8'h07: esc = "\\a";
                8'h09: esc = "\\t";
                8'h0d: esc = "\\r";
                8'h0c: esc = "\\f";
                8'h0b: esc = "\\v";
                "\"":  esc = "\\\"";
                default: esc = "";
            endcase
            if (esc.len() != 0)
            begin
                put_text(esc);
                advance_col(2);
                hex_pend = 1'b0;
            end
            else if (b == 8'h0a)
            begin
                // A newline also ends the source line and reopens the string.
                put_text("\\n\"\n  \"");
                line_col = '0;
                hex_pend = 1'b0;
            end
            else if (b < 32 || b >= 127 || (hex_pend && is_hex_digit(b)))
            begin
                // A hex digit right after a \x escape would extend it, so escape it too.
                put_text("\\x");
                put_hex(b);
                advance_col(4);
                hex_pend = 1'b1;
            end
            else
            begin
                char_buf.push_back(b);
                advance_col(1);
                hex_pend = 1'b0;
            end
        end
        else
        begin
            put_text("\\x");
            put_hex(b);
            advance_col(4);
        end
    endfunction

    // One element of a decimal or hex list; the column counts elements here.
    function void encode_list_byte(input logic [7:0] b);
        logic [7:0] h, t, u;
        h = b / 8'd100;
        t = (b / 8'd10) % 8'd10;
        u = b % 8'd10;
        if (!list_first)
            put_text(",");
        if (cfg_cols != 0 && line_col >= cfg_cols)
        begin
            put_text("\n  ");
            line_col = '0;
        end
        if (cfg_mode == MODE_HEXLIST)
        begin
            put_text("0x");
            put_hex(b);
        end
        else
        begin
            char_buf.push_back((h != 0) ? 8'("0" + h) : " ");
            char_buf.push_back((h != 0 || t != 0) ? 8'("0" + t) : " ");
            char_buf.push_back(8'("0" + u));
        end
        list_first = 1'b0;
        advance_col(1);
    endfunction

    // Works out the characters that one accepted item produces and queues them.
    function void encode_item(input logic item_op, input logic [7:0] b);
        char_buf.delete();
        if (item_op == OP_DATA && cfg_drop && b == CR_BYTE)
            return;
        if (!res_open)
        begin
            res_open = 1'b1;
            if (string_mode())
            begin
                put_text("=\n  \"");
            end
            else
            begin
                put_text("={");
                if (cfg_cols != 0)
                    put_text("\n  ");
            end
        end
        if (item_op == OP_DATA)
        begin
            if (string_mode())
                encode_string_byte(b);
            else
                encode_list_byte(b);
        end
        else
        begin
            if (string_mode())
            begin
                put_text("\"\n  ");
            end
            else
            begin
                if (cfg_cols != 0)
                    put_text("\n  ");
                put_text("}");
            end
            line_col = '0;
            hex_pend = 1'b0;
            list_first = 1'b1;
            res_open = 1'b0;
        end
        foreach (char_buf[i])
            text_due.push_back('{ch: char_buf[i], is_last: (i == char_buf.size() - 1)});
    endfunction

    // Sender. An accepted item is handed to the predictor at the edge that takes
    // it; the next item is offered right away or after its own idle cycles.
    always @(posedge clk)
    begin
        if (push && !full)
            encode_item(op, data_byte);
        if (!push || !full)
        begin
            if (rst_n && byte_feed.size() > 0 && byte_feed[0].gap > 0)
            begin
                byte_feed[0].gap = byte_feed[0].gap - 1;
                push <= 1'b0;
            end
            else if (rst_n && byte_feed.size() > 0)
            begin
                push <= 1'b1;
                op <= byte_feed[0].op;
                data_byte <= byte_feed[0].data;
                void'(byte_feed.pop_front());
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver. Every popped character is checked against the oldest one due.
    // After each character it idles a drawn number of cycles, or a long stretch
    // when the stimulus asks for one.
    int stall_left = 0;

    always @(posedge clk)
    begin
        text_char_t want;
        if (pop && !empty)
        begin
            if (text_due.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, actual %h last_char %b",
                         $time, out_char, last_char);
                errors++;
            end
            else
            begin
                want = text_due.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char mismatch, expected %h actual %h",
                             $time, want.ch, out_char);
                    errors++;
                end
                if (last_char !== want.is_last)
                begin
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, want.is_last, last_char);
                    errors++;
                end
            end
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
            pop <= 1'b0;
        end
        else if (pop && !empty)
        begin
            stall_left = idle_draw(recv_idle);
            if (stall_left > 0)
                pop <= 1'b0;
        end
        else if (!pop)
        begin
            stall_left--;
            if (stall_left <= 0)
                pop <= 1'b1;
        end
    end

    task automatic add_item(input logic item_op, input logic [7:0] b);
        byte_feed.push_back('{op: item_op, data: b, gap: idle_draw(send_idle)});
    endtask

    // Waits until every item went in and every character came out, then lets
    // the block settle so that a register write finds it idle.
    task automatic wait_idle();
        while (byte_feed.size() != 0 || push || text_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_MODE:        cfg_mode = val[1:0];
            REG_MAX_COLUMNS: cfg_cols = val;
            REG_DROP_CR:     cfg_drop = val[0];
            default:         ;
        endcase
    endtask

    // Bytes biased toward the ones with special handling: escapes, hex digits
    // that may follow an escape, printable text, and anything at all.
    function automatic logic [7:0] pick_byte();
        logic [7:0] specials[9] = '{"\\", 8'h07, 8'h09, 8'h0d, 8'h0c, 8'h0b, "\"", 8'h0a, 8'h7f};
        string hex_digits = "0123456789abcdefABCDEF";
        case ($urandom_range(0, 4))
            0:       return specials[$urandom_range(0, 8)];
            1:       return hex_digits[$urandom_range(0, 21)];
            2:       return 8'($urandom_range(32, 126));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random items that mostly form resources; a resource may be left open at
    // the end so that the next settings apply in the middle of it.
    task automatic add_random_items(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_item(OP_FINISH, 8'($urandom_range(0, 255)));
            else
                add_item(OP_DATA, pick_byte());
        end
    endtask

    initial
    begin
        logic [7:0] dec_bytes[5] = '{8'd0, 8'd9, 8'd99, 8'd100, 8'd255};
        logic [7:0] ascii_bytes[14] = '{"\\", 8'h07, 8'h09, 8'h0d, 8'h0c, 8'h0b, "\"", 8'h0a,
                                        8'h1f, 8'h7f, "a", "G", "~", " "};
        logic [9:0] cols;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset settings: a hex list with
        // the extreme bytes, then an empty resource.
        send_idle = IDLE_SOME;
        recv_idle = IDLE_SOME;
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'hff);
        add_item(OP_FINISH, 8'hff);
        add_item(OP_FINISH, 8'h00);

        // Decimal list without wrapping: one, two and three digit values.
        wait_idle();
        write_reg(REG_MODE, 10'(MODE_DEC));
        write_reg(REG_MAX_COLUMNS, 10'd0);
        foreach (dec_bytes[i])
            add_item(OP_DATA, dec_bytes[i]);
        add_item(OP_FINISH, 8'h5a);

        // Hex string with a narrow line, so every byte after the first wraps.
        wait_idle();
        write_reg(REG_MODE, 10'(MODE_HEXSTR));
        write_reg(REG_MAX_COLUMNS, 10'd2);
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'hff);
        add_item(OP_FINISH, 8'h00);

        // Escaped text: every escape but \r, a dropped carriage return, a newline,
        // bytes outside the printable range and a hex digit after an escape.
        wait_idle();
        write_reg(REG_MODE, 10'(MODE_ESCSTR));
        write_reg(REG_MAX_COLUMNS, 10'd1023);
        write_reg(REG_DROP_CR, 10'd1);
        foreach (ascii_bytes[i])
            add_item(OP_DATA, ascii_bytes[i]);
        add_item(OP_FINISH, 8'ha5);

        // Random phases. The first ones walk through every mode and the
        // extreme line widths; the idle pattern of both sides changes each time.
        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            case (p)
                0:       cols = 10'd0;
                1:       cols = 10'd1;
                2:       cols = 10'd1023;
                default: cols = 10'($urandom_range(2, 40));
            endcase
            write_reg(REG_MODE, (p < 4) ? 10'(p) : 10'($urandom_range(0, 3)));
            write_reg(REG_MAX_COLUMNS, cols);
            write_reg(REG_DROP_CR, 10'($urandom_range(0, 1)));
            send_idle = (p % 3 == 0) ? IDLE_NONE : int'($urandom_range(IDLE_SOME, IDLE_HEAVY));
            recv_idle = (p % 3 == 1) ? IDLE_NONE : int'($urandom_range(IDLE_SOME, IDLE_HEAVY));
            add_random_items(12);
        end

        // Back pressure: the receiver stops for a long time while the sender
        // keeps offering items back to back, so the block fills and stalls.
        wait_idle();
        write_reg(REG_MODE, 10'($urandom_range(0, 3)));
        write_reg(REG_MAX_COLUMNS, 10'($urandom_range(1, 20)));
        send_idle = IDLE_NONE;
        recv_idle = IDLE_SOME;
        hold_req = 1'b1;
        add_random_items(30);

        // A hex string line with wrapping off grows past any small limit; a
        // narrow limit set in the middle of the resource then wraps at once.
        wait_idle();
        write_reg(REG_MODE, 10'(MODE_HEXSTR));
        write_reg(REG_MAX_COLUMNS, 10'd0);
        write_reg(REG_DROP_CR, 10'd0);
        recv_idle = IDLE_NONE;
        for (int i = 0; i < 6; i++)
            add_item(OP_DATA, 8'($urandom_range(0, 255)));
        wait_idle();
        write_reg(REG_MAX_COLUMNS, 10'd8);
        add_item(OP_DATA, 8'($urandom_range(0, 255)));
        add_item(OP_DATA, 8'($urandom_range(0, 255)));
        add_item(OP_FINISH, 8'($urandom_range(0, 255)));

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
